@@ design/allocation_table_chain_engine_unit_macros.svh @@
// Assertion macros shared by the allocation table chain engine RTL.
`ifndef ALLOCATION_TABLE_CHAIN_ENGINE_UNIT_MACROS_SVH
`define ALLOCATION_TABLE_CHAIN_ENGINE_UNIT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ATCE_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check that a condition in one cycle implies a condition in the next cycle.
`define ATCE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/atce_pkg.sv @@
// Shared types and constants of the allocation table chain engine.
package atce_pkg;

  // Default number of table entries
  localparam int TableDepthDefault = 4096;

  // Block count register width and reset value
  localparam int DbcWidth = 13;
  localparam logic [DbcWidth-1:0] DbcReset = 13'd4096;

  // Entry value that closes a chain, and the free marker
  localparam logic [15:0] EndOfChain = 16'hFFFF;
  localparam logic [15:0] FreeEntry  = 16'h0000;

  typedef enum logic [2:0] {
    ACT_WRITE    = 3'd0,
    ACT_READ     = 3'd1,
    ACT_ALLOCATE = 3'd2,
    ACT_FREE     = 3'd3,
    ACT_WALK     = 3'd4,
    ACT_COUNT    = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_FULL   = 2'd1,
    STATUS_RANGE  = 2'd2,
    STATUS_BROKEN = 2'd3
  } status_e;

endpackage

@@ design/atce_if.sv @@
// Request and response channel interfaces of the allocation table chain engine.
interface atce_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [11:0] index;
  logic [15:0] value;
  logic [11:0] hops;

  modport source (output valid, action, index, value, hops, input ready);
  modport sink   (input valid, action, index, value, hops, output ready);
endinterface

interface atce_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] result_value;

  modport source (output valid, status, result_value, input ready);
  modport sink   (input valid, status, result_value, output ready);
endinterface

@@ design/allocation_table_chain_engine_unit.sv @@
// Allocation table chain engine: table memory, action sequencer and result register.
//
// Usage: one request channel (req_i) carries action, index, value and hops; one
// response channel (rsp_o) returns status and result_value, exactly one response
// per request, in order. cfg_we_i/cfg_wdata_i load the block count register; the
// user must do so only while the engine is idle, which the block does not enforce.
// The engine works on one request at a time. A transfer on req_i is taken only
// in the idle state; a finished result moves into the output register as soon
// as that register is free, and the engine returns to idle in the same cycle.
// With limit L = min(block count, TABLE_DEPTH): allocate scans from entry 1
// upward, one entry per cycle through the single read port, and stops at the
// first free entry; count scans every entry below L; free chain and walk follow
// one link at a time, since each link read depends on the one before through
// the memory latency.
// Reset clears the sequencer and the output valid and sets the block count to
// 4096; the table memory is not cleared and must be loaded by write actions
// before it is read.
// A stalled sink holds the response in the output register; the engine takes
// and works the next request meanwhile and holds that result until it frees.
`include "allocation_table_chain_engine_unit_macros.svh"

module allocation_table_chain_engine_unit #(
  parameter int TABLE_DEPTH = atce_pkg::TableDepthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [atce_pkg::DbcWidth-1:0] cfg_wdata_i,
  atce_in_if.sink                       req_i,
  atce_out_if.source                    rsp_o
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int LW = atce_pkg::DbcWidth;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISP     = 3'd1;
  localparam logic [2:0] S_RDATA    = 3'd2;
  localparam logic [2:0] S_SCAN     = 3'd3;
  localparam logic [2:0] S_CHAIN_RD = 3'd4;
  localparam logic [2:0] S_CHAIN_DT = 3'd5;
  localparam logic [2:0] S_OUT      = 3'd6;

  logic [2:0]              state_q, state_d;
  logic [LW-1:0]           dbc_q;
  logic [2:0]              act_q, act_d;
  logic [11:0]             idx_q, idx_d;
  logic [15:0]             val_q, val_d;
  logic [11:0]             hops_q, hops_d;
  logic [15:0]             cur_q, cur_d;
  logic [LW-1:0]           scan_q, scan_d;
  logic                    pend_q, pend_d;
  logic [LW-1:0]           pend_addr_q, pend_addr_d;
  logic [15:0]             res_q, res_d;
  atce_pkg::status_e       status_q, status_d;

  logic                    rsp_valid_q;
  atce_pkg::status_e       rsp_status_q;
  logic [15:0]             rsp_value_q;
  logic                    rsp_load;

  logic [15:0]             tbl_mem_q [TABLE_DEPTH];
  logic [15:0]             rdata_q;
  logic                    mem_we, mem_re;
  logic [AW-1:0]           mem_waddr, mem_raddr;
  logic [15:0]             mem_wdata;

  logic [LW-1:0]           lim;
  logic                    idx_ok;
  logic                    scan_issue;
  logic                    link_bad;
  logic [15:0]             res_inc;

  // Clamp the block count to the table depth
  assign lim = (32'(dbc_q) > TABLE_DEPTH) ? LW'(TABLE_DEPTH) : dbc_q;
  assign idx_ok = ({1'b0, idx_q} < lim);
  assign scan_issue = (scan_q < lim);
  assign link_bad = (rdata_q == atce_pkg::FreeEntry) || (rdata_q >= 16'(lim));
  assign res_inc = res_q + 16'd1;

  // Move a finished result into the output register once it is free
  assign rsp_load = (state_q == S_OUT) && (!rsp_valid_q || rsp_o.ready);

  assign req_i.ready = (state_q == S_IDLE);
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.status = rsp_status_q;
  assign rsp_o.result_value = rsp_value_q;

  // Sequence one action through the table memory
  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    idx_d       = idx_q;
    val_d       = val_q;
    hops_d      = hops_q;
    cur_d       = cur_q;
    scan_d      = scan_q;
    pend_d      = pend_q;
    pend_addr_d = pend_addr_q;
    res_d       = res_q;
    status_d    = status_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          act_d   = req_i.action;
          idx_d   = req_i.index;
          val_d   = req_i.value;
          hops_d  = req_i.hops;
          state_d = S_DISP;
        end
      end

      S_DISP: begin
        res_d    = '0;
        status_d = atce_pkg::STATUS_OK;
        cur_d    = 16'(idx_q);
        pend_d   = 1'b0;
        state_d  = S_OUT;
        unique case (atce_pkg::action_e'(act_q))
          atce_pkg::ACT_WRITE: begin
            if (idx_ok) begin
              mem_we    = 1'b1;
              mem_waddr = AW'(idx_q);
              mem_wdata = val_q;
              res_d     = val_q;
            end else begin
              status_d = atce_pkg::STATUS_RANGE;
            end
          end
          atce_pkg::ACT_READ: begin
            if (idx_ok) begin
              mem_re    = 1'b1;
              mem_raddr = AW'(idx_q);
              state_d   = S_RDATA;
            end else begin
              status_d = atce_pkg::STATUS_RANGE;
            end
          end
          atce_pkg::ACT_ALLOCATE: begin
            scan_d  = LW'(1);
            state_d = S_SCAN;
          end
          atce_pkg::ACT_COUNT: begin
            scan_d  = '0;
            state_d = S_SCAN;
          end
          atce_pkg::ACT_FREE: begin
            if (idx_ok) begin
              state_d = S_CHAIN_RD;
            end else begin
              status_d = atce_pkg::STATUS_RANGE;
            end
          end
          atce_pkg::ACT_WALK: begin
            if (!idx_ok) begin
              status_d = atce_pkg::STATUS_RANGE;
            end else if (hops_q == '0) begin
              res_d = 16'(idx_q);
            end else begin
              state_d = S_CHAIN_RD;
            end
          end
          default: begin
          end
        endcase
      end

      S_RDATA: begin
        res_d   = rdata_q;
        state_d = S_OUT;
      end

      S_SCAN: begin
        // Issue the next entry while the previous one returns
        mem_re      = scan_issue;
        mem_raddr   = AW'(scan_q);
        pend_d      = scan_issue;
        pend_addr_d = scan_q;
        if (scan_issue) begin
          scan_d = scan_q + LW'(1);
        end
        if (pend_q && (rdata_q == atce_pkg::FreeEntry)) begin
          if (act_q == atce_pkg::ACT_ALLOCATE) begin
            mem_we    = 1'b1;
            mem_waddr = AW'(pend_addr_q);
            mem_wdata = atce_pkg::EndOfChain;
            res_d     = 16'(pend_addr_q);
            state_d   = S_OUT;
          end else begin
            res_d = res_inc;
          end
        end else if (!pend_q && !scan_issue) begin
          if (act_q == atce_pkg::ACT_ALLOCATE) begin
            status_d = atce_pkg::STATUS_FULL;
          end
          state_d = S_OUT;
        end
      end

      S_CHAIN_RD: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(cur_q);
        state_d   = S_CHAIN_DT;
      end

      S_CHAIN_DT: begin
        state_d = S_CHAIN_RD;
        if (act_q == atce_pkg::ACT_FREE) begin
          // Clear the entry, then follow its link
          mem_we    = 1'b1;
          mem_waddr = AW'(cur_q);
          mem_wdata = atce_pkg::FreeEntry;
          res_d     = res_inc;
          if (rdata_q == atce_pkg::EndOfChain) begin
            state_d = S_OUT;
          end else if (link_bad || (res_inc >= 16'(lim))) begin
            status_d = atce_pkg::STATUS_BROKEN;
            state_d  = S_OUT;
          end else begin
            cur_d = rdata_q;
          end
        end else begin
          if ((rdata_q == atce_pkg::EndOfChain) || link_bad) begin
            status_d = atce_pkg::STATUS_BROKEN;
            res_d    = cur_q;
            state_d  = S_OUT;
          end else begin
            cur_d  = rdata_q;
            hops_d = hops_q - 12'd1;
            if (hops_q == 12'd1) begin
              res_d   = rdata_q;
              state_d = S_OUT;
            end
          end
        end
      end

      S_OUT: begin
        if (rsp_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold control state, the output valid and the block count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pend_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
      dbc_q       <= atce_pkg::DbcReset;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        dbc_q <= cfg_wdata_i;
      end
    end
  end

  // Hold the request and working payload
  always_ff @(posedge clk_i) begin
    act_q       <= act_d;
    idx_q       <= idx_d;
    val_q       <= val_d;
    hops_q      <= hops_d;
    cur_q       <= cur_d;
    scan_q      <= scan_d;
    pend_addr_q <= pend_addr_d;
    res_q       <= res_d;
    status_q    <= status_d;
  end

  // Load the response payload with the finished result
  always_ff @(posedge clk_i) begin
    if (rsp_load) begin
      rsp_status_q <= status_q;
      rsp_value_q  <= res_q;
    end
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tbl_mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= tbl_mem_q[mem_raddr];
    end
  end

  `ATCE_ASSERT(a_write_state, clk_i, rst_ni, !mem_we || (state_q == S_DISP) || (state_q == S_SCAN) || (state_q == S_CHAIN_DT), "table written outside a write state")
  `ATCE_ASSERT_NEXT(a_accept_disp, clk_i, rst_ni, req_i.valid && req_i.ready, state_q == S_DISP, "accepted request not dispatched")
  `ATCE_ASSERT(a_chain_order, clk_i, rst_ni, (state_q != S_CHAIN_DT) || ($past(state_q) == S_CHAIN_RD), "chain data without a chain read")
  `ATCE_ASSERT(a_scan_bound, clk_i, rst_ni, (state_q != S_SCAN) || (scan_q <= lim) || (lim == '0), "scan ran past the limit")
  `ATCE_ASSERT(a_full_alloc, clk_i, rst_ni, !((state_q == S_OUT) && (status_q == atce_pkg::STATUS_FULL)) || (act_q == atce_pkg::ACT_ALLOCATE), "full status on an action other than allocate")
  `ATCE_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_o.valid && !rsp_o.ready, rsp_o.valid, "response dropped while stalled")

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for the allocation table chain engine: directed rows, then random phases.
`timescale 1ns / 100ps

module tb_top;

  // Action code with no operation behind it
  localparam logic [2:0] ActSpare = 3'd7;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned NumDirected = 28;
  localparam int unsigned NumPhases = 11;

  typedef enum bit {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct {
    atce_pkg::status_e status;
    logic [15:0]       value;
  } outcome_t;

  typedef struct {
    row_kind_e         kind;
    logic [2:0]        action;
    logic [11:0]       index;
    logic [15:0]       value;
    logic [11:0]       hops;
    bit                typed;
    atce_pkg::status_e exp_status;
    logic [15:0]       exp_value;
  } stim_row_t;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          cfg_we;
  logic [atce_pkg::DbcWidth-1:0] cfg_wdata;

  atce_in_if  req_if ();
  atce_out_if rsp_if ();

  allocation_table_chain_engine_unit u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if.sink),
    .rsp_o       (rsp_if.source)
  );

  // Predictor state: table copy and block count register
  logic [15:0] alloc_tbl [atce_pkg::TableDepthDefault];
  int unsigned blk_count;

  outcome_t    pending_outcomes [$];
  logic [11:0] kept_heads [$];
  int unsigned mismatch_count = 0;
  bit          idle_off = 1'b0;

  // Directed rows; typed expectations where they are obvious, else predicted
  stim_row_t directed_rows [NumDirected] = '{
    '{ROW_REQ, atce_pkg::ACT_READ, 12'd4095, 16'd0, 12'd0, 1'b1, atce_pkg::STATUS_OK, 16'd0},
    '{ROW_REQ, atce_pkg::ACT_WRITE, 12'd0, 16'hFFFF, 12'd0, 1'b1, atce_pkg::STATUS_OK, 16'hFFFF},
    '{ROW_REQ, atce_pkg::ACT_COUNT, 12'd0, 16'd0, 12'd0, 1'b1, atce_pkg::STATUS_OK, 16'd4095},
    '{ROW_REQ, atce_pkg::ACT_ALLOCATE, 12'd0, 16'd0, 12'd0, 1'b1, atce_pkg::STATUS_OK, 16'd1},
    '{ROW_REQ, atce_pkg::ACT_ALLOCATE, 12'd0, 16'd0, 12'd0, 1'b1, atce_pkg::STATUS_OK, 16'd2},
    '{ROW_REQ, atce_pkg::ACT_WRITE, 12'd1, 16'd2, 12'd0, 1'b1, atce_pkg::STATUS_OK, 16'd2},
    '{ROW_REQ, atce_pkg::ACT_WALK, 12'd1, 16'd0, 12'd1, 1'b1, atce_pkg::STATUS_OK, 16'd2},
    '{ROW_REQ, atce_pkg::ACT_WALK, 12'd1, 16'd0, 12'd2, 1'b1, atce_pkg::STATUS_BROKEN, 16'd2},
    '{ROW_REQ, atce_pkg::ACT_WALK, 12'd4095, 16'd0, 12'd4095, 1'b1, atce_pkg::STATUS_BROKEN,
      16'd4095},
    '{ROW_REQ, atce_pkg::ACT_FREE, 12'd1, 16'd0, 12'd0, 1'b1, atce_pkg::STATUS_OK, 16'd2},
    '{ROW_REQ, atce_pkg::ACT_FREE, 12'd5, 16'd0, 12'd0, 1'b1, atce_pkg::STATUS_BROKEN, 16'd1},
    '{ROW_REQ, atce_pkg::ACT_WRITE, 12'd10, 16'd4095, 12'd0, 1'b0, atce_pkg::STATUS_OK, 16'd0},
    '{ROW_REQ, atce_pkg::ACT_WRITE, 12'd4095, 16'd10, 12'd0, 1'b0, atce_pkg::STATUS_OK, 16'd0},
    '{ROW_REQ, atce_pkg::ACT_WALK, 12'd10, 16'd0, 12'd4095, 1'b0, atce_pkg::STATUS_OK, 16'd0},
    '{ROW_REQ, atce_pkg::ACT_FREE, 12'd10, 16'd0, 12'd0, 1'b0, atce_pkg::STATUS_OK, 16'd0},
    '{ROW_REQ, atce_pkg::ACT_WRITE, 12'd3, 16'h1000, 12'd0, 1'b0, atce_pkg::STATUS_OK, 16'd0},
    '{ROW_REQ, atce_pkg::ACT_WALK, 12'd3, 16'd0, 12'd1, 1'b1, atce_pkg::STATUS_BROKEN, 16'd3},
    '{ROW_REQ, ActSpare, 12'd4095, 16'hFFFF, 12'd4095, 1'b1, atce_pkg::STATUS_OK, 16'd0},
    '{ROW_CFG, atce_pkg::ACT_WRITE, 12'd0, 16'd8, 12'd0, 1'b0, atce_pkg::STATUS_OK, 16'd0},
    '{ROW_REQ, atce_pkg::ACT_WRITE, 12'd8, 16'd1, 12'd0, 1'b1, atce_pkg::STATUS_RANGE, 16'd0},
    '{ROW_REQ, atce_pkg::ACT_WALK, 12'd4095, 16'd0, 12'd1, 1'b1, atce_pkg::STATUS_RANGE, 16'd0},
    '{ROW_CFG, atce_pkg::ACT_WRITE, 12'd0, 16'd1, 12'd0, 1'b0, atce_pkg::STATUS_OK, 16'd0},
    '{ROW_REQ, atce_pkg::ACT_ALLOCATE, 12'd0, 16'd0, 12'd0, 1'b1, atce_pkg::STATUS_FULL, 16'd0},
    '{ROW_CFG, atce_pkg::ACT_WRITE, 12'd0, 16'd0, 12'd0, 1'b0, atce_pkg::STATUS_OK, 16'd0},
    '{ROW_REQ, atce_pkg::ACT_COUNT, 12'd0, 16'd0, 12'd0, 1'b1, atce_pkg::STATUS_OK, 16'd0},
    '{ROW_REQ, atce_pkg::ACT_READ, 12'd0, 16'd0, 12'd0, 1'b1, atce_pkg::STATUS_RANGE, 16'd0},
    '{ROW_CFG, atce_pkg::ACT_WRITE, 12'd0, 16'd8191, 12'd0, 1'b0, atce_pkg::STATUS_OK, 16'd0},
    '{ROW_REQ, atce_pkg::ACT_WRITE, 12'd4095, 16'd0, 12'd0, 1'b1, atce_pkg::STATUS_OK, 16'd0}
  };

  // Random phases: block count setting and number of requests in each
  int unsigned phase_counts [NumPhases] = '{16, 1, 64, 2, 8191, 0, 200, 7, 4095, 33, 4096};
  int unsigned phase_items  [NumPhases] = '{230, 15, 230, 40, 20, 12, 230, 150, 15, 250, 20};

  always #10 clk = ~clk;

  function automatic int unsigned live_limit();
    return (blk_count > atce_pkg::TableDepthDefault) ? atce_pkg::TableDepthDefault : blk_count;
  endfunction

  // Apply one action to the table copy and return its status and result
  function automatic outcome_t table_outcome(input logic [2:0] act, input logic [11:0] idx,
                                             input logic [15:0] val, input logic [11:0] hops);
    outcome_t    o;
    int unsigned lim, cur, nxt, k;
    lim      = live_limit();
    o.status = atce_pkg::STATUS_OK;
    o.value  = 16'h0000;
    case (act)
      atce_pkg::ACT_WRITE: begin
        if (32'(idx) < lim) begin
          alloc_tbl[idx] = val;
          o.value = val;
        end else begin
          o.status = atce_pkg::STATUS_RANGE;
        end
      end
      atce_pkg::ACT_READ: begin
        if (32'(idx) < lim) o.value = alloc_tbl[idx];
        else o.status = atce_pkg::STATUS_RANGE;
      end
      atce_pkg::ACT_ALLOCATE: begin
        o.status = atce_pkg::STATUS_FULL;
        for (k = 1; k < lim; k++) begin
          if (alloc_tbl[k] == atce_pkg::FreeEntry) begin
            alloc_tbl[k] = atce_pkg::EndOfChain;
            o.value  = 16'(k);
            o.status = atce_pkg::STATUS_OK;
            break;
          end
        end
      end
      atce_pkg::ACT_FREE: begin
        if (32'(idx) >= lim) begin
          o.status = atce_pkg::STATUS_RANGE;
        end else begin
          cur = 32'(idx);
          o.status = atce_pkg::STATUS_BROKEN;
          // Clear along the chain, bounded by the limit
          for (k = 0; k < lim; k++) begin
            nxt = 32'(alloc_tbl[cur]);
            alloc_tbl[cur] = atce_pkg::FreeEntry;
            o.value++;
            if (nxt == 32'(atce_pkg::EndOfChain)) begin
              o.status = atce_pkg::STATUS_OK;
              break;
            end
            if (nxt == 32'(atce_pkg::FreeEntry) || nxt >= lim) break;
            cur = nxt;
          end
        end
      end
      atce_pkg::ACT_WALK: begin
        if (32'(idx) >= lim) begin
          o.status = atce_pkg::STATUS_RANGE;
        end else begin
          cur = 32'(idx);
          for (k = 0; k < 32'(hops); k++) begin
            nxt = 32'(alloc_tbl[cur]);
            if (nxt == 32'(atce_pkg::EndOfChain) || nxt == 32'(atce_pkg::FreeEntry) ||
                nxt >= lim) begin
              o.status = atce_pkg::STATUS_BROKEN;
              break;
            end
            cur = nxt;
          end
          o.value = 16'(cur);
        end
      end
      atce_pkg::ACT_COUNT: begin
        for (k = 0; k < lim; k++)
          if (alloc_tbl[k] == atce_pkg::FreeEntry) o.value++;
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic int unsigned draw_wait();
    return idle_off ? 0 : $urandom_range(0, 7);
  endfunction

  // Mostly in range, sometimes any 12-bit index
  function automatic logic [11:0] pick_index();
    int unsigned lim;
    lim = live_limit();
    if (lim > 0 && $urandom_range(0, 9) != 0) return 12'($urandom_range(0, lim - 1));
    return 12'($urandom);
  endfunction

  function automatic logic [15:0] pick_value();
    int unsigned lim;
    lim = live_limit();
    case ($urandom_range(0, 3))
      0: return (lim > 1) ? 16'($urandom_range(1, lim - 1)) : atce_pkg::EndOfChain;
      1: return atce_pkg::EndOfChain;
      2: return atce_pkg::FreeEntry;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [11:0] pick_hops();
    if ($urandom_range(0, 3) != 0) return 12'($urandom_range(0, 8));
    return 12'($urandom);
  endfunction

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch: %s", what);
  endtask

  // Drive one request, hold it until the transfer, then queue its expected outcome
  task automatic send_request(input logic [2:0] act, input logic [11:0] idx,
                              input logic [15:0] val, input logic [11:0] hops,
                              output outcome_t got, input bit typed = 1'b0,
                              input atce_pkg::status_e typed_status = atce_pkg::STATUS_OK,
                              input logic [15:0] typed_value = 16'h0000);
    int unsigned gap;
    outcome_t    want;
    gap = draw_wait();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid  <= 1'b1;
    req_if.action <= act;
    req_if.index  <= idx;
    req_if.value  <= val;
    req_if.hops   <= hops;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    got  = table_outcome(act, idx, val, hops);
    want = got;
    if (typed) begin
      want.status = typed_status;
      want.value  = typed_value;
    end
    pending_outcomes.push_back(want);
  endtask

  // Drain all responses, then write the block count register
  task automatic load_block_count(input logic [atce_pkg::DbcWidth-1:0] count);
    req_if.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= count;
    @(posedge clk);
    cfg_we    <= 1'b0;
    blk_count = 32'(count);
  endtask

  // Mostly build, walk and free chains; the rest is noise on any action
  task automatic run_random_phase(input int unsigned count_value, input int unsigned quota);
    int unsigned issued, links, j, pos;
    logic [11:0] head, tail;
    logic [2:0]  act;
    outcome_t    got;
    load_block_count(atce_pkg::DbcWidth'(count_value));
    idle_off = ($urandom_range(0, 3) == 0);
    kept_heads.delete();
    issued = 0;
    while (issued < quota) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          send_request(atce_pkg::ACT_ALLOCATE, 12'($urandom), 16'($urandom), 12'($urandom),
                       got);
          issued++;
          if (got.status == atce_pkg::STATUS_OK) begin
            head  = got.value[11:0];
            tail  = head;
            links = $urandom_range(0, 5);
            // Grow the chain one allocated entry at a time
            for (j = 0; j < links; j++) begin
              send_request(atce_pkg::ACT_ALLOCATE, 12'($urandom), 16'($urandom),
                           12'($urandom), got);
              issued++;
              if (got.status != atce_pkg::STATUS_OK) break;
              send_request(atce_pkg::ACT_WRITE, tail, got.value, 12'($urandom), got);
              issued++;
              tail = got.value[11:0];
            end
            if ($urandom_range(0, 1) == 1) begin
              send_request(atce_pkg::ACT_WALK, head, 16'($urandom),
                           12'($urandom_range(0, links + 2)), got);
              issued++;
            end
            if ($urandom_range(0, 3) != 0) begin
              send_request(atce_pkg::ACT_FREE, head, 16'($urandom), 12'($urandom), got);
              issued++;
            end else begin
              kept_heads.push_back(head);
            end
          end
        end
        6: begin
          if (kept_heads.size() > 0) begin
            pos  = $urandom_range(0, kept_heads.size() - 1);
            head = kept_heads[pos];
            kept_heads.delete(pos);
            act  = ($urandom_range(0, 1) == 1) ? atce_pkg::ACT_WALK : atce_pkg::ACT_FREE;
            send_request(act, head, 16'($urandom), pick_hops(), got);
            issued++;
          end
        end
        default: begin
          act = 3'($urandom_range(0, 7));
          send_request(act, pick_index(), pick_value(), pick_hops(), got);
          if (act <= atce_pkg::ACT_COUNT) issued++;
        end
      endcase
    end
  endtask

  // Response side: random stalls, compare each transfer with the oldest expectation
  initial begin
    int unsigned stall;
    outcome_t    want;
    rsp_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (rsp_if.valid !== 1'b1);
      if (pending_outcomes.size() == 0) begin
        flag_mismatch($sformatf("response with nothing awaited: status %0d result 0x%04h",
                                rsp_if.status, rsp_if.result_value));
      end else begin
        want = pending_outcomes.pop_front();
        if (rsp_if.status !== want.status)
          flag_mismatch($sformatf("status expected %0d got %0d", want.status,
                                  rsp_if.status));
        if (rsp_if.result_value !== want.value)
          flag_mismatch($sformatf("result expected 0x%04h got 0x%04h", want.value,
                                  rsp_if.result_value));
      end
    end
  end

  // Request side and run control
  initial begin
    outcome_t got;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    req_if.valid   = 1'b0;
    req_if.action  = atce_pkg::ACT_WRITE;
    req_if.index   = '0;
    req_if.value   = '0;
    req_if.hops    = '0;
    blk_count      = 32'(atce_pkg::DbcReset);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Load every entry as free so no scan ever meets an unwritten entry
    idle_off = 1'b1;
    for (int i = 0; i < atce_pkg::TableDepthDefault; i++)
      send_request(atce_pkg::ACT_WRITE, 12'(i), atce_pkg::FreeEntry, 12'd0, got);
    idle_off = 1'b0;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_CFG)
        load_block_count(directed_rows[r].value[atce_pkg::DbcWidth-1:0]);
      else
        send_request(directed_rows[r].action, directed_rows[r].index, directed_rows[r].value,
                     directed_rows[r].hops, got, directed_rows[r].typed,
                     directed_rows[r].exp_status, directed_rows[r].exp_value);
    end

    foreach (phase_counts[p]) run_random_phase(phase_counts[p], phase_items[p]);

    // Drain, then allow time for any stray response
    req_if.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[allocation_table_chain_engine_unit] OK");
    end else begin
      $display("[allocation_table_chain_engine_unit] ERROR");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #100ms;
    $display("[allocation_table_chain_engine_unit] ERROR");
    $finish;
  end

endmodule
